>>> src/afis_pkg.sv
// Shared types and constants of the arm/fire interlock sequencer.
package afis_pkg;

    localparam int VALVE_COUNT   = 10;
    localparam int IGNITER_COUNT = 2;

    localparam logic [3:0] OP_DEBUG       = 4'd0;
    localparam logic [3:0] OP_PASSIVE     = 4'd1;
    localparam logic [3:0] OP_TEST        = 4'd2;
    localparam logic [3:0] OP_ENTER_OFFNOM = 4'd3;
    localparam logic [3:0] OP_EXIT_OFFNOM = 4'd4;
    localparam logic [3:0] OP_ABORT       = 4'd5;
    localparam logic [3:0] OP_VENT        = 4'd6;
    localparam logic [3:0] OP_HP_ARM      = 4'd7;
    localparam logic [3:0] OP_HP_PRESS    = 4'd8;
    localparam logic [3:0] OP_TANK_ARM    = 4'd9;
    localparam logic [3:0] OP_TANK_PRESS  = 4'd10;
    localparam logic [3:0] OP_FIRE_ARM    = 4'd11;
    localparam logic [3:0] OP_FIRE        = 4'd12;
    localparam logic [3:0] OP_VALVE       = 4'd13;
    localparam logic [3:0] OP_IGNITER     = 4'd14;
    localparam logic [3:0] OP_SENSORS     = 4'd15;

    localparam logic [3:0] MODE_PASSIVE    = 4'd0;
    localparam logic [3:0] MODE_TEST       = 4'd1;
    localparam logic [3:0] MODE_HP_ARM     = 4'd2;
    localparam logic [3:0] MODE_HP_PRESS   = 4'd3;
    localparam logic [3:0] MODE_TANK_ARM   = 4'd4;
    localparam logic [3:0] MODE_TANK_PRESS = 4'd5;
    localparam logic [3:0] MODE_FIRE_ARMED = 4'd6;
    localparam logic [3:0] MODE_FIRE       = 4'd7;
    localparam logic [3:0] MODE_ABORT      = 4'd8;
    localparam logic [3:0] MODE_VENT       = 4'd9;
    localparam logic [3:0] MODE_OFFNOM     = 4'd10;
    localparam logic [3:0] MODE_DEBUG      = 4'd11;

    localparam logic [1:0] SEQ_NONE    = 2'd0;
    localparam logic [1:0] SEQ_HOLD    = 2'd1;
    localparam logic [1:0] SEQ_STANDBY = 2'd2;
    localparam logic [1:0] SEQ_RUN     = 2'd3;

    localparam logic [2:0] TK_NONE    = 3'd0;
    localparam logic [2:0] TK_PASSIVE = 3'd1;
    localparam logic [2:0] TK_ARMED   = 3'd2;
    localparam logic [2:0] TK_DOME    = 3'd3;
    localparam logic [2:0] TK_VENT    = 3'd4;

    localparam logic [1:0] ENG_NONE    = 2'd0;
    localparam logic [1:0] ENG_PASSIVE = 2'd1;
    localparam logic [1:0] ENG_SEQ     = 2'd2;

    localparam logic [1:0] DEV_NONE    = 2'd0;
    localparam logic [1:0] DEV_VALVE   = 2'd1;
    localparam logic [1:0] DEV_IGNITER = 2'd2;
    localparam logic [1:0] DEV_SENSORS = 2'd3;

    localparam logic [2:0] SET_MAX_BINARY = 3'd1;
    localparam logic [2:0] SET_MAX_SENSOR = 3'd4;

    typedef struct packed {
        logic [3:0] operation;
        logic [3:0] target;
        logic [2:0] setting;
    } in_word_t;

    typedef struct packed {
        logic [3:0] vehicle_state;
        logic       halt;
        logic [1:0] sequence_mode;
        logic [2:0] high_press_mode;
        logic [2:0] lox_tank_mode;
        logic [2:0] fuel_tank_mode;
        logic [1:0] engine_mode;
        logic [1:0] device_kind;
        logic [3:0] device_index;
        logic [2:0] device_value;
    } out_word_t;

    typedef struct packed {
        logic [3:0] current_mode;
        logic [3:0] saved_mode;
        logic       halt;
    } ctrl_state_t;

endpackage

>>> src/arm_fire_interlock_sequencer.sv
// Top level of the arm/fire interlock sequencer: state registers and result register.
//
//   Channel  Ports                       Word
//   input    s_valid, s_ready, s_word    afis_pkg::in_word_t (operation, target, setting)
//   result   m_valid, m_ready, m_word    afis_pkg::out_word_t (one word per command)
//
// Each command is decoded in the cycle it is accepted; its result word is
// registered and shown on the next cycle, one command per cycle sustained while m_ready stays high.
// The mode, saved mode and halt latch update at the same edge as the result register.
// Synchronous active-low reset sets the mode to passive and clears halt and m_valid.
// A stalled result only blocks input when the result register is still full.
module arm_fire_interlock_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  afis_pkg::in_word_t  s_word,
    output logic                m_valid,
    input  logic                m_ready,
    output afis_pkg::out_word_t m_word
);

    afis_pkg::ctrl_state_t state_reg;
    afis_pkg::ctrl_state_t state_next;
    afis_pkg::out_word_t   word_reg;
    afis_pkg::out_word_t   word_next;
    logic                  valid_reg;
    logic                  accept;

    afis_decode u_decode (
        .cmd        (s_word),
        .state      (state_reg),
        .state_next (state_next),
        .word       (word_next)
    );

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = valid_reg;
    assign m_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.current_mode <= afis_pkg::MODE_PASSIVE;
            state_reg.saved_mode   <= afis_pkg::MODE_PASSIVE;
            state_reg.halt         <= 1'b0;
            valid_reg              <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            word_reg <= word_next;
        end
    end

    a_result_tracks_state: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (word_reg.vehicle_state == state_reg.current_mode) &&
                      (word_reg.halt == state_reg.halt))
        else $error("result word disagrees with the control state");

    a_abort_sets_halt: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_word.operation == afis_pkg::OP_ABORT) |=>
            state_reg.halt && (state_reg.current_mode == afis_pkg::MODE_ABORT))
        else $error("abort did not latch halt");

    a_mode_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.current_mode <= afis_pkg::MODE_DEBUG &&
        state_reg.saved_mode <= afis_pkg::MODE_DEBUG)
        else $error("mode register out of range");

    a_no_device_no_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && (word_reg.device_kind == afis_pkg::DEV_NONE) |->
            (word_reg.device_index == 4'd0) && (word_reg.device_value == 3'd0))
        else $error("device payload without a device order");

endmodule

>>> src/afis_decode.sv
// Command decoder: next control state and result word for one command.
module afis_decode (
    input  afis_pkg::in_word_t    cmd,
    input  afis_pkg::ctrl_state_t state,
    output afis_pkg::ctrl_state_t state_next,
    output afis_pkg::out_word_t   word
);

    logic       direct_ok;
    logic       valve_in_range;
    logic       igniter_in_range;
    logic       binary_ok;
    logic [1:0] seq;
    logic [2:0] hp;
    logic [2:0] lox;
    logic [2:0] fuel;
    logic [1:0] eng;

    assign direct_ok = (state.current_mode == afis_pkg::MODE_TEST) ||
                       (state.current_mode == afis_pkg::MODE_OFFNOM);
    assign valve_in_range   = {1'b0, cmd.target} < 5'(afis_pkg::VALVE_COUNT);
    assign igniter_in_range = {1'b0, cmd.target} < 5'(afis_pkg::IGNITER_COUNT);
    assign binary_ok = cmd.setting <= afis_pkg::SET_MAX_BINARY;

    always_comb begin
        state_next        = state;
        seq               = afis_pkg::SEQ_NONE;
        hp                = afis_pkg::TK_NONE;
        lox               = afis_pkg::TK_NONE;
        fuel              = afis_pkg::TK_NONE;
        eng               = afis_pkg::ENG_NONE;
        word.device_kind  = afis_pkg::DEV_NONE;
        word.device_index = 4'd0;
        word.device_value = 3'd0;
        case (cmd.operation)
            afis_pkg::OP_DEBUG: begin
                state_next.current_mode = afis_pkg::MODE_DEBUG;
            end
            afis_pkg::OP_PASSIVE: begin
                seq  = afis_pkg::SEQ_HOLD;
                hp   = afis_pkg::TK_PASSIVE;
                lox  = afis_pkg::TK_PASSIVE;
                fuel = afis_pkg::TK_PASSIVE;
                eng  = afis_pkg::ENG_PASSIVE;
                state_next.current_mode = afis_pkg::MODE_PASSIVE;
                state_next.halt         = 1'b0;
            end
            afis_pkg::OP_TEST: begin
                if (state.current_mode == afis_pkg::MODE_PASSIVE) begin
                    state_next.current_mode = afis_pkg::MODE_TEST;
                end
            end
            afis_pkg::OP_ENTER_OFFNOM: begin
                state_next.saved_mode   = state.current_mode;
                state_next.current_mode = afis_pkg::MODE_OFFNOM;
            end
            afis_pkg::OP_EXIT_OFFNOM: begin
                if (state.current_mode == afis_pkg::MODE_OFFNOM) begin
                    state_next.current_mode = state.saved_mode;
                end
            end
            afis_pkg::OP_ABORT: begin
                seq = afis_pkg::SEQ_HOLD;
                state_next.current_mode = afis_pkg::MODE_ABORT;
                state_next.halt         = 1'b1;
            end
            afis_pkg::OP_VENT: begin
                seq  = afis_pkg::SEQ_HOLD;
                hp   = afis_pkg::TK_PASSIVE;
                lox  = afis_pkg::TK_VENT;
                fuel = afis_pkg::TK_VENT;
                eng  = afis_pkg::ENG_PASSIVE;
                state_next.current_mode = afis_pkg::MODE_VENT;
            end
            afis_pkg::OP_HP_ARM: begin
                if (state.current_mode == afis_pkg::MODE_PASSIVE) begin
                    seq  = afis_pkg::SEQ_STANDBY;
                    hp   = afis_pkg::TK_ARMED;
                    lox  = afis_pkg::TK_PASSIVE;
                    fuel = afis_pkg::TK_PASSIVE;
                    eng  = afis_pkg::ENG_PASSIVE;
                    state_next.current_mode = afis_pkg::MODE_HP_ARM;
                end
            end
            afis_pkg::OP_HP_PRESS: begin
                if (state.current_mode inside {afis_pkg::MODE_HP_ARM,
                                               afis_pkg::MODE_TANK_ARM}) begin
                    seq  = afis_pkg::SEQ_STANDBY;
                    hp   = afis_pkg::TK_DOME;
                    lox  = afis_pkg::TK_PASSIVE;
                    fuel = afis_pkg::TK_PASSIVE;
                    eng  = afis_pkg::ENG_PASSIVE;
                    state_next.current_mode = afis_pkg::MODE_HP_PRESS;
                end
            end
            afis_pkg::OP_TANK_ARM: begin
                if (state.current_mode == afis_pkg::MODE_HP_PRESS) begin
                    seq  = afis_pkg::SEQ_STANDBY;
                    hp   = afis_pkg::TK_DOME;
                    lox  = afis_pkg::TK_ARMED;
                    fuel = afis_pkg::TK_ARMED;
                    eng  = afis_pkg::ENG_PASSIVE;
                    state_next.current_mode = afis_pkg::MODE_TANK_ARM;
                end
            end
            afis_pkg::OP_TANK_PRESS: begin
                if (state.current_mode == afis_pkg::MODE_TANK_ARM) begin
                    seq  = afis_pkg::SEQ_STANDBY;
                    hp   = afis_pkg::TK_DOME;
                    lox  = afis_pkg::TK_DOME;
                    fuel = afis_pkg::TK_DOME;
                    eng  = afis_pkg::ENG_PASSIVE;
                    state_next.current_mode = afis_pkg::MODE_TANK_PRESS;
                end
            end
            afis_pkg::OP_FIRE_ARM: begin
                if (state.current_mode == afis_pkg::MODE_TANK_PRESS) begin
                    seq  = afis_pkg::SEQ_STANDBY;
                    hp   = afis_pkg::TK_DOME;
                    lox  = afis_pkg::TK_DOME;
                    fuel = afis_pkg::TK_DOME;
                    eng  = afis_pkg::ENG_PASSIVE;
                    state_next.current_mode = afis_pkg::MODE_FIRE_ARMED;
                end
            end
            afis_pkg::OP_FIRE: begin
                if (state.current_mode == afis_pkg::MODE_FIRE_ARMED) begin
                    seq  = afis_pkg::SEQ_RUN;
                    hp   = afis_pkg::TK_DOME;
                    lox  = afis_pkg::TK_DOME;
                    fuel = afis_pkg::TK_DOME;
                    eng  = afis_pkg::ENG_SEQ;
                    state_next.current_mode = afis_pkg::MODE_FIRE;
                end
            end
            afis_pkg::OP_VALVE: begin
                if (direct_ok && valve_in_range && binary_ok) begin
                    word.device_kind  = afis_pkg::DEV_VALVE;
                    word.device_index = cmd.target;
                    word.device_value = cmd.setting;
                end
            end
            afis_pkg::OP_IGNITER: begin
                if (direct_ok && igniter_in_range && binary_ok) begin
                    word.device_kind  = afis_pkg::DEV_IGNITER;
                    word.device_index = cmd.target;
                    word.device_value = cmd.setting;
                end
            end
            default: begin
                if ((state.current_mode == afis_pkg::MODE_TEST) &&
                    (cmd.setting <= afis_pkg::SET_MAX_SENSOR)) begin
                    word.device_kind  = afis_pkg::DEV_SENSORS;
                    word.device_value = cmd.setting;
                end
            end
        endcase
        word.vehicle_state   = state_next.current_mode;
        word.halt            = state_next.halt;
        word.sequence_mode   = seq;
        word.high_press_mode = hp;
        word.lox_tank_mode   = lox;
        word.fuel_tank_mode  = fuel;
        word.engine_mode     = eng;
    end

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the arm/fire interlock sequencer: directed and random commands.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_COMMANDS = 1200;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 10;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    afis_pkg::in_word_t  s_word;
    logic                m_valid;
    logic                m_ready;
    afis_pkg::out_word_t m_word;

    logic [3:0] mode_now;
    logic [3:0] mode_saved;
    logic       halt_now;

    afis_pkg::out_word_t pending_results[$];
    afis_pkg::out_word_t oldest_result;
    int         mismatch_count;
    int         results_seen;
    int         quiet_cycles;
    bit         idling_on;
    bit         hold_off_request;

    arm_fire_interlock_sequencer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic afis_pkg::out_word_t with_orders(afis_pkg::out_word_t r,
                                                        logic [1:0] seq, logic [2:0] hp,
                                                        logic [2:0] lox, logic [2:0] fuel,
                                                        logic [1:0] eng);
        r.sequence_mode   = seq;
        r.high_press_mode = hp;
        r.lox_tank_mode   = lox;
        r.fuel_tank_mode  = fuel;
        r.engine_mode     = eng;
        return r;
    endfunction

    // Applies one command to the predicted interlock state and returns its result word.
    function automatic afis_pkg::out_word_t interlock_step(afis_pkg::in_word_t cmd);
        afis_pkg::out_word_t r;
        logic                direct_ok;
        r = '0;
        direct_ok = (mode_now == afis_pkg::MODE_TEST) || (mode_now == afis_pkg::MODE_OFFNOM);
        case (cmd.operation)
            afis_pkg::OP_DEBUG: mode_now = afis_pkg::MODE_DEBUG;
            afis_pkg::OP_PASSIVE: begin
                r = with_orders(r, afis_pkg::SEQ_HOLD, afis_pkg::TK_PASSIVE,
                                afis_pkg::TK_PASSIVE, afis_pkg::TK_PASSIVE,
                                afis_pkg::ENG_PASSIVE);
                mode_now = afis_pkg::MODE_PASSIVE;
                halt_now = 1'b0;
            end
            afis_pkg::OP_TEST: begin
                if (mode_now == afis_pkg::MODE_PASSIVE) mode_now = afis_pkg::MODE_TEST;
            end
            afis_pkg::OP_ENTER_OFFNOM: begin
                mode_saved = mode_now;
                mode_now   = afis_pkg::MODE_OFFNOM;
            end
            afis_pkg::OP_EXIT_OFFNOM: begin
                if (mode_now == afis_pkg::MODE_OFFNOM) mode_now = mode_saved;
            end
            afis_pkg::OP_ABORT: begin
                halt_now = 1'b1;
                mode_now = afis_pkg::MODE_ABORT;
                r.sequence_mode = afis_pkg::SEQ_HOLD;
            end
            afis_pkg::OP_VENT: begin
                r = with_orders(r, afis_pkg::SEQ_HOLD, afis_pkg::TK_PASSIVE,
                                afis_pkg::TK_VENT, afis_pkg::TK_VENT, afis_pkg::ENG_PASSIVE);
                mode_now = afis_pkg::MODE_VENT;
            end
            afis_pkg::OP_HP_ARM: begin
                if (mode_now == afis_pkg::MODE_PASSIVE) begin
                    r = with_orders(r, afis_pkg::SEQ_STANDBY, afis_pkg::TK_ARMED,
                                    afis_pkg::TK_PASSIVE, afis_pkg::TK_PASSIVE,
                                    afis_pkg::ENG_PASSIVE);
                    mode_now = afis_pkg::MODE_HP_ARM;
                end
            end
            afis_pkg::OP_HP_PRESS: begin
                if (mode_now == afis_pkg::MODE_HP_ARM || mode_now == afis_pkg::MODE_TANK_ARM) begin
                    r = with_orders(r, afis_pkg::SEQ_STANDBY, afis_pkg::TK_DOME,
                                    afis_pkg::TK_PASSIVE, afis_pkg::TK_PASSIVE,
                                    afis_pkg::ENG_PASSIVE);
                    mode_now = afis_pkg::MODE_HP_PRESS;
                end
            end
            afis_pkg::OP_TANK_ARM: begin
                if (mode_now == afis_pkg::MODE_HP_PRESS) begin
                    r = with_orders(r, afis_pkg::SEQ_STANDBY, afis_pkg::TK_DOME,
                                    afis_pkg::TK_ARMED, afis_pkg::TK_ARMED,
                                    afis_pkg::ENG_PASSIVE);
                    mode_now = afis_pkg::MODE_TANK_ARM;
                end
            end
            afis_pkg::OP_TANK_PRESS: begin
                if (mode_now == afis_pkg::MODE_TANK_ARM) begin
                    r = with_orders(r, afis_pkg::SEQ_STANDBY, afis_pkg::TK_DOME,
                                    afis_pkg::TK_DOME, afis_pkg::TK_DOME,
                                    afis_pkg::ENG_PASSIVE);
                    mode_now = afis_pkg::MODE_TANK_PRESS;
                end
            end
            afis_pkg::OP_FIRE_ARM: begin
                if (mode_now == afis_pkg::MODE_TANK_PRESS) begin
                    r = with_orders(r, afis_pkg::SEQ_STANDBY, afis_pkg::TK_DOME,
                                    afis_pkg::TK_DOME, afis_pkg::TK_DOME,
                                    afis_pkg::ENG_PASSIVE);
                    mode_now = afis_pkg::MODE_FIRE_ARMED;
                end
            end
            afis_pkg::OP_FIRE: begin
                if (mode_now == afis_pkg::MODE_FIRE_ARMED) begin
                    r = with_orders(r, afis_pkg::SEQ_RUN, afis_pkg::TK_DOME,
                                    afis_pkg::TK_DOME, afis_pkg::TK_DOME, afis_pkg::ENG_SEQ);
                    mode_now = afis_pkg::MODE_FIRE;
                end
            end
            afis_pkg::OP_VALVE: begin
                if (direct_ok && cmd.target < afis_pkg::VALVE_COUNT
                        && cmd.setting <= afis_pkg::SET_MAX_BINARY) begin
                    r.device_kind  = afis_pkg::DEV_VALVE;
                    r.device_index = cmd.target;
                    r.device_value = cmd.setting;
                end
            end
            afis_pkg::OP_IGNITER: begin
                if (direct_ok && cmd.target < afis_pkg::IGNITER_COUNT
                        && cmd.setting <= afis_pkg::SET_MAX_BINARY) begin
                    r.device_kind  = afis_pkg::DEV_IGNITER;
                    r.device_index = cmd.target;
                    r.device_value = cmd.setting;
                end
            end
            default: begin
                if (mode_now == afis_pkg::MODE_TEST
                        && cmd.setting <= afis_pkg::SET_MAX_SENSOR) begin
                    r.device_kind  = afis_pkg::DEV_SENSORS;
                    r.device_value = cmd.setting;
                end
            end
        endcase
        r.vehicle_state = mode_now;
        r.halt          = halt_now;
        return r;
    endfunction

    function automatic afis_pkg::in_word_t make_command(logic [3:0] op, logic [3:0] tgt,
                                                        logic [2:0] set);
        afis_pkg::in_word_t c;
        c.operation = op;
        c.target    = tgt;
        c.setting   = set;
        return c;
    endfunction

    // Mostly the next legal step for the predicted mode, with some mode-free and raw commands.
    function automatic afis_pkg::in_word_t pick_command();
        afis_pkg::in_word_t c;
        int                 r;
        c.operation = 4'($urandom_range(15));
        c.target    = 4'($urandom_range(15));
        c.setting   = 3'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 60) begin
            case (mode_now)
                afis_pkg::MODE_PASSIVE: begin
                    c.operation = $urandom_range(1) ? afis_pkg::OP_HP_ARM : afis_pkg::OP_TEST;
                end
                afis_pkg::MODE_HP_ARM:     c.operation = afis_pkg::OP_HP_PRESS;
                afis_pkg::MODE_HP_PRESS:   c.operation = afis_pkg::OP_TANK_ARM;
                afis_pkg::MODE_TANK_ARM: begin
                    c.operation = ($urandom_range(3) == 0) ? afis_pkg::OP_HP_PRESS
                                                           : afis_pkg::OP_TANK_PRESS;
                end
                afis_pkg::MODE_TANK_PRESS: c.operation = afis_pkg::OP_FIRE_ARM;
                afis_pkg::MODE_FIRE_ARMED: c.operation = afis_pkg::OP_FIRE;
                afis_pkg::MODE_TEST, afis_pkg::MODE_OFFNOM: begin
                    case ($urandom_range(4))
                        0, 1: begin
                            c.operation = afis_pkg::OP_VALVE;
                            c.target    = 4'($urandom_range(afis_pkg::VALVE_COUNT - 1));
                            c.setting   = 3'($urandom_range(1));
                        end
                        2: begin
                            c.operation = afis_pkg::OP_IGNITER;
                            c.target    = 4'($urandom_range(afis_pkg::IGNITER_COUNT - 1));
                            c.setting   = 3'($urandom_range(1));
                        end
                        3: begin
                            c.operation = afis_pkg::OP_SENSORS;
                            c.setting   = 3'($urandom_range(4));
                        end
                        default: begin
                            c.operation = (mode_now == afis_pkg::MODE_TEST)
                                          ? afis_pkg::OP_ENTER_OFFNOM
                                          : afis_pkg::OP_EXIT_OFFNOM;
                        end
                    endcase
                end
                default:         c.operation = afis_pkg::OP_PASSIVE;
            endcase
        end else if (r < 75) begin
            case ($urandom_range(4))
                0:       c.operation = afis_pkg::OP_ABORT;
                1:       c.operation = afis_pkg::OP_VENT;
                2:       c.operation = afis_pkg::OP_ENTER_OFFNOM;
                3:       c.operation = afis_pkg::OP_DEBUG;
                default: c.operation = afis_pkg::OP_PASSIVE;
            endcase
        end
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("MISMATCH: %s", msg);
    endtask

    task automatic check_field(string name, logic [3:0] got, logic [3:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    task automatic send_command(afis_pkg::in_word_t cmd);
        if (idling_on && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= cmd;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(interlock_step(cmd));
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_arming_chain();
        send_command(make_command(afis_pkg::OP_HP_ARM, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_HP_PRESS, 4'd15, 3'd7));
        send_command(make_command(afis_pkg::OP_TANK_ARM, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_HP_PRESS, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_TANK_ARM, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_TANK_PRESS, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_FIRE_ARM, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_FIRE, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_FIRE, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_ABORT, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_TEST, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_PASSIVE, 4'd0, 3'd0));
    endtask

    task automatic test_direct_orders();
        send_command(make_command(afis_pkg::OP_VALVE, 4'd1, 3'd1));
        send_command(make_command(afis_pkg::OP_TEST, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_VALVE, 4'(afis_pkg::VALVE_COUNT - 1), 3'd1));
        send_command(make_command(afis_pkg::OP_VALVE, 4'(afis_pkg::VALVE_COUNT), 3'd0));
        send_command(make_command(afis_pkg::OP_VALVE, 4'd3, 3'd2));
        send_command(make_command(afis_pkg::OP_IGNITER, 4'(afis_pkg::IGNITER_COUNT - 1),
                                  3'd1));
        send_command(make_command(afis_pkg::OP_IGNITER, 4'(afis_pkg::IGNITER_COUNT), 3'd0));
        send_command(make_command(afis_pkg::OP_SENSORS, 4'd15, afis_pkg::SET_MAX_SENSOR));
        send_command(make_command(afis_pkg::OP_SENSORS, 4'd0, 3'd7));
    endtask

    task automatic test_offnominal();
        send_command(make_command(afis_pkg::OP_ENTER_OFFNOM, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_ENTER_OFFNOM, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_VALVE, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_SENSORS, 4'd0, 3'd1));
        send_command(make_command(afis_pkg::OP_EXIT_OFFNOM, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_VENT, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_EXIT_OFFNOM, 4'd0, 3'd0));
        send_command(make_command(afis_pkg::OP_DEBUG, 4'd0, 3'd0));
        wait_all_results();
    endtask

    task automatic test_random_commands(int count);
        idling_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i == count / 4) idling_on = 1'b1;
            send_command(pick_command());
        end
        wait_all_results();
    endtask

    task automatic test_input_stall();
        idling_on = 1'b0;
        hold_off_request = 1'b1;
        for (int i = 0; i < 40; i++) send_command(pick_command());
        wait_all_results();
        idling_on = 1'b1;
    endtask

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_word           = '0;
        mode_now         = afis_pkg::MODE_PASSIVE;
        mode_saved       = afis_pkg::MODE_PASSIVE;
        halt_now         = 1'b0;
        mismatch_count   = 0;
        results_seen     = 0;
        idling_on        = 1'b1;
        hold_off_request = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_arming_chain();
        test_direct_orders();
        test_offnominal();
        test_random_commands(RANDOM_COMMANDS / 2);
        test_input_stall();
        test_random_commands(RANDOM_COMMANDS / 2);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[arm_fire_interlock_sequencer] OK");
        end else begin
            $display("[arm_fire_interlock_sequencer] ERROR");
        end
        $finish;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_request = 1'b0;
            end else if (!idling_on) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 24);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no command pending",
                                          results_seen));
            end else begin
                oldest_result = pending_results.pop_front();
                check_field("vehicle_state", m_word.vehicle_state, oldest_result.vehicle_state);
                check_field("halt", 4'(m_word.halt), 4'(oldest_result.halt));
                check_field("sequence_mode", 4'(m_word.sequence_mode),
                            4'(oldest_result.sequence_mode));
                check_field("high_press_mode", 4'(m_word.high_press_mode),
                            4'(oldest_result.high_press_mode));
                check_field("lox_tank_mode", 4'(m_word.lox_tank_mode),
                            4'(oldest_result.lox_tank_mode));
                check_field("fuel_tank_mode", 4'(m_word.fuel_tank_mode),
                            4'(oldest_result.fuel_tank_mode));
                check_field("engine_mode", 4'(m_word.engine_mode),
                            4'(oldest_result.engine_mode));
                check_field("device_kind", 4'(m_word.device_kind),
                            4'(oldest_result.device_kind));
                check_field("device_index", m_word.device_index, oldest_result.device_index);
                check_field("device_value", 4'(m_word.device_value),
                            4'(oldest_result.device_value));
            end
        end
    end

    initial quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[arm_fire_interlock_sequencer] ERROR");
            $finish;
        end
    end

endmodule
